// File: sv/nps_pkg.sv
// Package with the shared constants of the next prime search block.
package nps_pkg;
  localparam int unsigned SIEVE_LIMIT = 65536;
  localparam int unsigned TABLE_DEPTH = 8192;
  localparam int unsigned VALUE_BITS  = 31;
  localparam int unsigned PRIME_W     = 16;
  localparam int unsigned PSQ_W       = 2 * PRIME_W;
endpackage

// File: sv/nps_if.sv
// Valid/ready channel interfaces for the input word and the result word.
interface nps_in_if #(parameter int unsigned ValueBits = 31);
  logic                 valid;
  logic                 ready;
  logic [ValueBits-1:0] n_value;
  modport source (output valid, output n_value, input ready);
  modport sink   (input valid, input n_value, output ready);
endinterface

interface nps_out_if #(parameter int unsigned ValueBits = 31);
  logic                 valid;
  logic                 ready;
  logic [ValueBits-1:0] prime_value;
  logic                 was_prime;
  modport source (output valid, output prime_value, output was_prime, input ready);
  modport sink   (input valid, input prime_value, input was_prime, output ready);
endinterface

// File: sv/nps_sieve.sv
// Sieve of Eratosthenes over a one-bit mark memory, feeding the prime table.
module nps_sieve #(
  parameter int unsigned SieveLimit = nps_pkg::SIEVE_LIMIT,
  parameter int unsigned TableDepth = nps_pkg::TABLE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  output logic                                tbl_we_o,
  output logic [$clog2(TableDepth)-1:0]       tbl_waddr_o,
  output logic [nps_pkg::PRIME_W-1:0]         tbl_wdata_o,
  output logic [$clog2(TableDepth):0]         count_o,
  output logic                                done_o
);
  import nps_pkg::*;

  localparam int unsigned LimW = $clog2(SieveLimit);
  localparam int unsigned TblW = $clog2(TableDepth);
  localparam int unsigned SqW  = 2 * LimW + 1;
  localparam logic [SqW-1:0]  LimSq   = SqW'(SieveLimit);
  localparam logic [LimW:0]   LimJ    = (LimW+1)'(SieveLimit);
  localparam logic [LimW-1:0] LastIdx = LimW'(SieveLimit - 1);
  localparam logic [TblW:0]   DepthC  = (TblW+1)'(TableDepth);

  localparam logic [2:0] SV_CLR  = 3'd0;
  localparam logic [2:0] SV_RD   = 3'd1;
  localparam logic [2:0] SV_CHK  = 3'd2;
  localparam logic [2:0] SV_MARK = 3'd3;
  localparam logic [2:0] SV_DONE = 3'd4;

  logic            marks [SieveLimit];
  logic            mark_rd_q;
  logic [2:0]      state_q, state_d;
  logic [LimW-1:0] i_q, i_d;
  logic [LimW:0]   j_q, j_d;
  logic [SqW-1:0]  sq_q;
  logic [TblW:0]   cnt_q, cnt_d;
  logic            m_we;
  logic [LimW-1:0] m_addr;
  logic            m_wdata;
  logic            m_re;
  logic [LimW:0]   j_next;

  assign j_next = j_q + (LimW+1)'(i_q);

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    cnt_d       = cnt_q;
    m_we        = 1'b0;
    m_addr      = i_q;
    m_wdata     = 1'b0;
    m_re        = 1'b0;
    tbl_we_o    = 1'b0;
    tbl_waddr_o = cnt_q[TblW-1:0];
    tbl_wdata_o = PRIME_W'(i_q);
    unique case (state_q)
      SV_CLR: begin
        m_we = 1'b1;
        if (i_q == LastIdx) begin
          i_d     = LimW'(2);
          state_d = SV_RD;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      SV_RD: begin
        m_re    = 1'b1;
        state_d = SV_CHK;
      end
      SV_CHK: begin
        if (!mark_rd_q && cnt_q < DepthC) begin
          tbl_we_o = 1'b1;
          cnt_d    = cnt_q + 1'b1;
        end
        if (!mark_rd_q && sq_q < LimSq) begin
          j_d     = sq_q[LimW:0];
          state_d = SV_MARK;
        end else if (i_q == LastIdx) begin
          state_d = SV_DONE;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = SV_RD;
        end
      end
      SV_MARK: begin
        m_we    = 1'b1;
        m_addr  = j_q[LimW-1:0];
        m_wdata = 1'b1;
        j_d     = j_next;
        if (j_next >= LimJ) begin
          if (i_q == LastIdx) begin
            state_d = SV_DONE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = SV_RD;
          end
        end
      end
      SV_DONE: ;
      default: state_d = SV_DONE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (m_we) begin
      marks[m_addr] <= m_wdata;
    end
    if (m_re) begin
      mark_rd_q <= marks[m_addr];
      sq_q      <= SqW'(i_q) * SqW'(i_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SV_CLR;
      i_q     <= '0;
      j_q     <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      cnt_q   <= cnt_d;
    end
  end

  assign count_o = cnt_q;
  assign done_o  = (state_q == SV_DONE);
endmodule

// File: sv/nps_table.sv
// Prime table memory: one write port, one registered read port.
module nps_table #(
  parameter int unsigned TableDepth = nps_pkg::TABLE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [$clog2(TableDepth)-1:0]     waddr_i,
  input  logic [nps_pkg::PRIME_W-1:0]       wdata_i,
  input  logic                              re_i,
  input  logic [$clog2(TableDepth)-1:0]     raddr_i,
  output logic [nps_pkg::PRIME_W-1:0]       rdata_o
);
  import nps_pkg::*;

  logic [PRIME_W-1:0] mem [TableDepth];
  logic [PRIME_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// File: sv/nps_div.sv
// Bit-serial remainder unit: one dividend bit per cycle.
module nps_div #(
  parameter int unsigned ValueBits = nps_pkg::VALUE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ValueBits-1:0]          dividend_i,
  input  logic [nps_pkg::PRIME_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic                          rem_zero_o
);
  import nps_pkg::*;

  localparam int unsigned CntW = $clog2(ValueBits + 1);

  logic                 busy_q;
  logic                 done_q;
  logic [CntW-1:0]      cnt_q;
  logic [ValueBits-1:0] v_q;
  logic [PRIME_W-1:0]   d_q;
  logic [PRIME_W-1:0]   rem_q;
  logic [PRIME_W:0]     trial;
  logic [PRIME_W-1:0]   rem_d;

  always_comb begin
    trial = {rem_q, v_q[ValueBits-1]};
    if (trial >= {1'b0, d_q}) begin
      rem_d = PRIME_W'(trial - {1'b0, d_q});
    end else begin
      rem_d = trial[PRIME_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= dividend_i;
      d_q   <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      v_q   <= v_q << 1;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(ValueBits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign rem_zero_o = (rem_q == '0);
endmodule

// File: sv/nps_search.sv
// Candidate search: trial division over the prime table, one prime at a time.
module nps_search #(
  parameter int unsigned TableDepth = nps_pkg::TABLE_DEPTH,
  parameter int unsigned ValueBits  = nps_pkg::VALUE_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              table_ready_i,
  input  logic [$clog2(TableDepth):0]       count_i,
  output logic                              rd_en_o,
  output logic [$clog2(TableDepth)-1:0]     rd_addr_o,
  input  logic [nps_pkg::PRIME_W-1:0]       rd_data_i,
  nps_in_if.sink                            in_i,
  nps_out_if.source                         out_o
);
  import nps_pkg::*;

  localparam int unsigned TblW = $clog2(TableDepth);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TEST  = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]           state_q;
  logic [ValueBits-1:0] cand_q;
  logic                 first_q;
  logic [TblW:0]        k_q;
  logic [PRIME_W-1:0]   p_q;
  logic [PSQ_W-1:0]     sq_q;
  logic                 out_valid_q;
  logic [ValueBits-1:0] out_prime_q;
  logic                 out_was_q;
  logic                 div_start;
  logic                 div_done;
  logic                 div_zero;
  logic                 load_out;

  nps_div #(.ValueBits(ValueBits)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cand_q),
    .divisor_i  (p_q),
    .done_o     (div_done),
    .rem_zero_o (div_zero)
  );

  assign in_i.ready = (state_q == S_IDLE) && table_ready_i;
  assign rd_en_o    = (state_q == S_ISSUE);
  assign rd_addr_o  = k_q[TblW-1:0];
  assign div_start  = (state_q == S_CMP) && !(sq_q > PSQ_W'(cand_q));
  assign load_out   = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD) begin
      p_q  <= rd_data_i;
      sq_q <= PSQ_W'(rd_data_i) * PSQ_W'(rd_data_i);
    end
    if (load_out) begin
      out_prime_q <= cand_q;
      out_was_q   <= first_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cand_q      <= '0;
      first_q     <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid && in_i.ready) begin
            cand_q  <= in_i.n_value;
            first_q <= 1'b1;
            state_q <= S_TEST;
          end
        end
        S_TEST: begin
          // Zero and one are not prime: step on without touching the table.
          if (cand_q < ValueBits'(2)) begin
            first_q <= 1'b0;
            cand_q  <= cand_q + 1'b1;
          end else begin
            k_q     <= '0;
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: state_q <= S_LOAD;
        S_LOAD:  state_q <= S_CMP;
        S_CMP: begin
          if (div_start) begin
            state_q <= S_DIV;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (div_zero) begin
              first_q <= 1'b0;
              cand_q  <= cand_q + 1'b1;
              state_q <= S_TEST;
            end else if (k_q + 1'b1 == count_i) begin
              // Table exhausted with no divisor found: taken as prime.
              state_q <= S_DONE;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_ISSUE;
            end
          end
        end
        S_DONE: begin
          if (load_out) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.prime_value = out_prime_q;
  assign out_o.was_prime   = out_was_q;
endmodule

// File: sv/next_prime_search.sv
// Top level of the next prime search block.
//
//  channel | dir | payload                          | handshake
//  in_i    | in  | n_value [ValueBits]              | valid / ready
//  out_o   | out | prime_value [ValueBits], was_prime | valid / ready
//
// After reset the mark memory is cleared, then sieved (each index is read and
// checked, then the multiples of each prime from its square up are marked);
// in_i.ready stays low until then. Per word, each trial divisor passes through
// the bit-serial remainder unit, and the divisors run up to the square root of
// each candidate, over every candidate of the prime gap. One word is in flight
// at a time; a finished word waits in the output register, and the next word
// is taken as soon as it is loaded there.
module next_prime_search #(
  parameter int unsigned SieveLimit = nps_pkg::SIEVE_LIMIT,
  parameter int unsigned TableDepth = nps_pkg::TABLE_DEPTH,
  parameter int unsigned ValueBits  = nps_pkg::VALUE_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nps_in_if.sink    in_i,
  nps_out_if.source out_o
);
  import nps_pkg::*;

  localparam int unsigned TblW = $clog2(TableDepth);

  logic                tbl_we;
  logic [TblW-1:0]     tbl_waddr;
  logic [PRIME_W-1:0]  tbl_wdata;
  logic [TblW:0]       count;
  logic                sieve_done;
  logic                rd_en;
  logic [TblW-1:0]     rd_addr;
  logic [PRIME_W-1:0]  rd_data;

  // Sieve fills the prime table in ascending order after reset.
  nps_sieve #(.SieveLimit(SieveLimit), .TableDepth(TableDepth)) u_sieve (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tbl_we_o    (tbl_we),
    .tbl_waddr_o (tbl_waddr),
    .tbl_wdata_o (tbl_wdata),
    .count_o     (count),
    .done_o      (sieve_done)
  );

  nps_table #(.TableDepth(TableDepth)) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // The search only reads the table, and only after the sieve is done.
  nps_search #(.TableDepth(TableDepth), .ValueBits(ValueBits)) u_search (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .table_ready_i (sieve_done),
    .count_i       (count),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .in_i          (in_i),
    .out_o         (out_o)
  );
endmodule

// File: sv/nps_checker.sv
// Port-level checks for the next prime search block, with their bind.
module nps_checker #(
  parameter int unsigned ValueBits = nps_pkg::VALUE_BITS
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [ValueBits-1:0] prime_value_i,
  input logic                 was_prime_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(prime_value_i) && $stable(was_prime_i))
    else $error("result word changed while stalled");

  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second word taken while one is in flight");

  a_prime_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> prime_value_i >= ValueBits'(2))
    else $error("result below two");
endmodule

bind next_prime_search nps_checker #(.ValueBits(ValueBits)) u_nps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .prime_value_i (out_o.prime_value),
  .was_prime_i   (out_o.was_prime)
);

// File: test/next_prime_search_test.sv
// Testbench for the next prime search block: directed and random words with a checked scoreboard.
`timescale 1ns / 1ps

module next_prime_search_test;
  localparam int unsigned VB = nps_pkg::VALUE_BITS;
  localparam int unsigned HOLD_CYCLES = 3000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  nps_in_if  #(.ValueBits(VB)) in_if ();
  nps_out_if #(.ValueBits(VB)) out_if ();

  next_prime_search u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  typedef struct packed {
    logic [VB-1:0] prime_value;
    logic          was_prime;
  } prime_answer_t;

  logic [VB-1:0] pending_values[$];
  prime_answer_t expected_answers[$];
  int unsigned mismatch_count = 0;
  int unsigned answer_count = 0;
  int unsigned prime_hits = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;
  bit stim_loaded = 1'b0;

  // Plain trial division; every prime below the square root is covered.
  function automatic bit value_is_prime(longint unsigned v);
    longint unsigned d;
    if (v < 2) return 1'b0;
    if (v < 4) return 1'b1;
    if (v % 2 == 0) return 1'b0;
    for (d = 3; d * d <= v; d += 2)
      if (v % d == 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic prime_answer_t next_prime_at_or_above(logic [VB-1:0] n);
    prime_answer_t   a;
    longint unsigned c;
    c = n;
    a.was_prime = value_is_prime(c);
    while (!value_is_prime(c))
      c = (c + 1) & ((64'd1 << VB) - 1);
    a.prime_value = c[VB-1:0];
    return a;
  endfunction

  // Sender: bursts of random length separated by random gaps. A word stays on the
  // bus until it is taken; the prediction is made at the accepting edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.n_value <= '0;
    end else begin
      if (in_if.valid && in_if.ready)
        expected_answers.push_back(next_prime_at_or_above(in_if.n_value));
      if (in_if.valid && !in_if.ready) begin
        // Hold the offered word.
      end else if (gap_left > 0) begin
        gap_left    <= gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (pending_values.size() > 0) begin
        in_if.valid   <= 1'b1;
        in_if.n_value <= pending_values.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(8, 1);
          gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Long hold-off once, counted here so the block fills and stalls its input.
  // It starts while the cheap small values are still in flight, so the block
  // finishes one word into its output register and stalls on the next.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && answer_count == 3) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: random stall pattern, and the scoreboard check at each accepted word.
  always @(posedge clk_i or negedge rst_ni) begin
    prime_answer_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= (hold_left == 0) && (answer_count < 30 || $urandom_range(3, 0) != 0);
      if (out_if.valid && out_if.ready) begin
        answer_count <= answer_count + 1;
        if (expected_answers.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("unexpected word: prime_value=%0d was_prime=%0d",
                     out_if.prime_value, out_if.was_prime);
        end else begin
          want = expected_answers.pop_front();
          if (want.was_prime) prime_hits <= prime_hits + 1;
          if (want.prime_value !== out_if.prime_value || want.was_prime !== out_if.was_prime)
          begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("mismatch: expected %0d/%0d, got %0d/%0d",
                       want.prime_value, want.was_prime,
                       out_if.prime_value, out_if.was_prime);
          end
        end
      end
    end
  end

  // Stimulus: directed corners, then mostly values below the sieve range, some up
  // to 2**20 and a few full-range ones, since large values cost far more cycles.
  initial begin
    logic [VB-1:0] v;
    pending_values.push_back(0);
    pending_values.push_back(1);
    pending_values.push_back(2);
    pending_values.push_back(3);
    pending_values.push_back(4);
    pending_values.push_back(24);
    pending_values.push_back(65521);
    pending_values.push_back(65535);
    pending_values.push_back(65536);
    pending_values.push_back(65537);
    pending_values.push_back(VB'(64'd4294967291 & ((64'd1 << VB) - 1)));
    pending_values.push_back(2147483646);
    pending_values.push_back(2147483647);
    pending_values.push_back(2147483629);
    pending_values.push_back(1073741824);
    pending_values.push_back(1431655765);
    for (int i = 0; i < 100; i++) begin
      if (i % 12 == 0) v = VB'($urandom());
      else if (i % 3 == 0) v = VB'($urandom_range(1 << 20, 0));
      else v = VB'($urandom_range(65535, 0));
      pending_values.push_back(v);
    end
    stim_loaded = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    wait (stim_loaded && rst_ni);
    while (pending_values.size() > 0 || in_if.valid) @(posedge clk_i);
    while (expected_answers.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("covered %0d result words (%0d inputs already prime), including a long receiver stall",
             answer_count, prime_hits);
    $display("mismatches: %0d, words still awaited: %0d", mismatch_count,
             expected_answers.size());
    if (mismatch_count == 0 && expected_answers.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #400_000_000;
    $display("timeout after %0d result words", answer_count);
    $display("status: fail");
    $finish;
  end
endmodule

// File: next_prime_search.f
sv/nps_pkg.sv
sv/nps_if.sv
sv/nps_sieve.sv
sv/nps_table.sv
sv/nps_div.sv
sv/nps_search.sv
sv/next_prime_search.sv
sv/nps_checker.sv
test/next_prime_search_test.sv
